[src/mpt_pkg.sv]
package mpt_pkg;

  localparam int unsigned TILE_DEPTH = 64;
  localparam int unsigned SPARS_W    = 17;
  localparam int unsigned PADDR_W    = 3;

  // register word index carried in paddr[2]
  localparam logic REG_SPARSITY = 1'b0;

  typedef struct packed {
    logic [31:0] weight_bits;
    logic        tile_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pruned_bits;
    logic        result_last;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] weight;
  } cell_word_t;

  typedef struct packed {
    logic        valid;
    logic [30:0] mag;
  } cell_mag_t;

  typedef struct packed {
    logic load;
    logic copy;
    logic step;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COPY,
    ST_COUNT,
    ST_EMIT
  } state_e;

endpackage

[src/mpt_cell.sv]
module mpt_cell #(
  parameter int unsigned LessW = $clog2(mpt_pkg::TILE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpt_pkg::cell_ctl_t ctl_i,
  input  mpt_pkg::cell_word_t word_i,
  input  logic [LessW-1:0]   less_i,
  input  mpt_pkg::cell_mag_t mag_i,
  output mpt_pkg::cell_word_t word_o,
  output logic [LessW-1:0]   less_o,
  output mpt_pkg::cell_mag_t mag_o
);

  logic             word_valid_q;
  logic [31:0]      weight_q;
  logic [LessW-1:0] less_q;
  logic             mag_valid_q;
  logic [30:0]      mag_q;
  logic             hit;

  // passing magnitude is strictly smaller than the held one
  assign hit = mag_valid_q && word_valid_q && (mag_q < weight_q[30:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
      mag_valid_q  <= 1'b0;
    end else begin
      if (ctl_i.load || ctl_i.shift) begin
        word_valid_q <= word_i.valid;
      end
      if (ctl_i.copy) begin
        mag_valid_q <= word_valid_q;
      end else if (ctl_i.step) begin
        mag_valid_q <= mag_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load || ctl_i.shift) begin
      weight_q <= word_i.weight;
    end
    if (ctl_i.shift) begin
      less_q <= less_i;
    end else if (ctl_i.copy) begin
      less_q <= '0;
    end else if (ctl_i.step && hit) begin
      less_q <= less_q + LessW'(1);
    end
    if (ctl_i.copy) begin
      mag_q <= weight_q[30:0];
    end else if (ctl_i.step) begin
      mag_q <= mag_i.mag;
    end
  end

  assign word_o.valid  = word_valid_q;
  assign word_o.weight = weight_q;
  assign less_o        = less_q;
  assign mag_o.valid   = mag_valid_q;
  assign mag_o.mag     = mag_q;

endmodule

[src/magnitude_prune_tile.sv]
// magnitude_prune_tile: magnitude pruning of one tile of single-precision weights
//
// input channel (in_valid_i / in_ready_o / in_item_i) takes one weight per item;
// tile_last closes the tile, as does the item that fills TileDepth entries.
// apb port: register 0 is the sparsity fraction, unsigned q1.16, 17 bits.
// output channel (out_valid_o / out_ready_i / out_item_o) returns the whole tile
// in arrival order, result_last on its final item, pruned weights as +0.
// a tile of n items passes through load (one item per cycle while in_valid_i is
// high), a copy step, rank counting while the magnitudes circulate around the ring
// of cells, then shifting that moves the tile out through the top cell.
// in_ready_o is high only while loading; the next tile may load while the
// final item of the previous one still waits in the output register.
// a stalled receiver holds the output register and freezes the shift chain.
// reset empties the cells and the output register and clears the sparsity
// register to zero, which passes tiles unchanged.
module magnitude_prune_tile #(
  parameter int unsigned TileDepth = mpt_pkg::TILE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mpt_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mpt_pkg::out_item_t            out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned CntW  = $clog2(TileDepth + 1);
  localparam int unsigned LessW = $clog2(TileDepth);
  localparam int unsigned ProdW = CntW + mpt_pkg::SPARS_W;

  mpt_pkg::state_e state_q, state_d;

  logic [mpt_pkg::SPARS_W-1:0] spars_q;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  k_q;
  logic             zero_all_q, thr_q;
  logic [LessW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  mpt_pkg::out_item_t out_item_q, out_item_d;

  logic             accept, close_tile, emit_go, prune;
  logic [CntW-1:0]  n_new;
  logic [ProdW-1:0] prod;
  logic [CntW-1:0]  k_new;
  logic             thr_new;
  mpt_pkg::cell_ctl_t ctl;

  mpt_pkg::cell_word_t word_in [TileDepth];
  mpt_pkg::cell_word_t word_out[TileDepth];
  logic [LessW-1:0]    less_in [TileDepth];
  logic [LessW-1:0]    less_out[TileDepth];
  mpt_pkg::cell_mag_t  mag_in  [TileDepth];
  mpt_pkg::cell_mag_t  mag_out [TileDepth];

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mpt_pkg::REG_SPARSITY) ?
                  {{(32 - mpt_pkg::SPARS_W){1'b0}}, spars_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spars_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mpt_pkg::REG_SPARSITY) begin
      spars_q <= pwdata[mpt_pkg::SPARS_W-1:0];
    end
  end

  // tile close and rank k
  assign in_ready_o = (state_q == mpt_pkg::ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign close_tile = accept &&
                      (in_item_i.tile_last || fill_q == CntW'(TileDepth - 1));
  assign n_new      = fill_q + CntW'(1);
  assign prod       = ProdW'(n_new) * ProdW'(spars_q);
  assign k_new      = prod[16 +: CntW];
  assign thr_new    = (spars_q != '0) && !spars_q[16] &&
                      (k_new != '0) && (k_new < n_new);

  always_ff @(posedge clk_i) begin
    if (close_tile) begin
      k_q        <= k_new;
      zero_all_q <= spars_q[16];
      thr_q      <= thr_new;
    end
  end

  // chain control
  assign emit_go = (state_q == mpt_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctl.load  = accept;
    ctl.copy  = (state_q == mpt_pkg::ST_COPY);
    ctl.step  = (state_q == mpt_pkg::ST_COUNT);
    ctl.shift = emit_go;
  end

  genvar gi;
  generate
    for (gi = 0; gi < TileDepth; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign word_in[gi].valid  = (state_q == mpt_pkg::ST_LOAD);
        assign word_in[gi].weight = in_item_i.weight_bits;
        assign less_in[gi]        = '0;
        assign mag_in[gi]         = mag_out[TileDepth-1];
      end else begin : g_body
        assign word_in[gi] = word_out[gi-1];
        assign less_in[gi] = less_out[gi-1];
        assign mag_in[gi]  = mag_out[gi-1];
      end

      mpt_cell #(
        .LessW(LessW)
      ) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctl_i (ctl),
        .word_i(word_in[gi]),
        .less_i(less_in[gi]),
        .mag_i (mag_in[gi]),
        .word_o(word_out[gi]),
        .less_o(less_out[gi]),
        .mag_o (mag_out[gi])
      );
    end
  endgenerate

  // rank of the top cell decides pruning, unless the whole tile is zeroed
  assign prune = zero_all_q || (thr_q && (CntW'(less_out[TileDepth-1]) <= k_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpt_pkg::ST_LOAD: begin
        if (close_tile) state_d = mpt_pkg::ST_COPY;
      end
      mpt_pkg::ST_COPY: begin
        state_d = mpt_pkg::ST_COUNT;
      end
      mpt_pkg::ST_COUNT: begin
        if (step_q == LessW'(TileDepth - 1)) state_d = mpt_pkg::ST_EMIT;
      end
      mpt_pkg::ST_EMIT: begin
        if (emit_go && word_out[TileDepth-1].valid && rem_q == CntW'(1)) begin
          state_d = mpt_pkg::ST_LOAD;
        end
      end
      default: state_d = mpt_pkg::ST_LOAD;
    endcase
  end

  // datapath and counters
  always_comb begin
    fill_d      = fill_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    case (state_q)
      mpt_pkg::ST_LOAD: begin
        if (close_tile) begin
          fill_d = '0;
          rem_d  = n_new;
        end else if (accept) begin
          fill_d = n_new;
        end
        step_d = '0;
      end
      mpt_pkg::ST_COUNT: begin
        step_d = step_q + LessW'(1);
      end
      mpt_pkg::ST_EMIT: begin
        if (emit_go && word_out[TileDepth-1].valid) begin
          rem_d = rem_q - CntW'(1);
        end
      end
      default: begin
        step_d = '0;
      end
    endcase
    if (emit_go) begin
      out_valid_d = word_out[TileDepth-1].valid;
      out_item_d.pruned_bits = prune ? 32'd0 : word_out[TileDepth-1].weight;
      out_item_d.result_last = (rem_q == CntW'(1));
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpt_pkg::ST_LOAD;
      fill_q      <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TileDepth - 1))
    else $error("fill count beyond tile depth");

  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpt_pkg::ST_EMIT) |-> (rem_q != '0))
    else $error("emission with nothing left");

  a_close_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.tile_last) |=> (state_q == mpt_pkg::ST_COPY))
    else $error("tile close did not start ranking");

  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpt_pkg::ST_COUNT) |-> !(thr_q && zero_all_q))
    else $error("threshold and zero-all both set");
`endif

endmodule

[test/magnitude_prune_tile_test.sv]
`timescale 1ns / 100ps

module magnitude_prune_tile_test;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 2 * mpt_pkg::TILE_DEPTH + 16;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SPARS_NONE    = 0;
  localparam int unsigned SPARS_QUARTER = 16384;
  localparam int unsigned SPARS_HALF    = 32768;
  localparam int unsigned SPARS_3Q      = 49152;
  localparam int unsigned SPARS_FULL    = 65536;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;
  typedef enum logic [1:0] {WS_RANDOM, WS_TIES, WS_SPECIAL} weight_style_e;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  mpt_pkg::in_item_t           in_item_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  mpt_pkg::out_item_t          out_item_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [mpt_pkg::PADDR_W-1:0] paddr       = '0;
  logic [31:0]                 pwdata      = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  logic [31:0]        pending_weights[$];
  mpt_pkg::out_item_t expected_pruned[$];
  logic [16:0]        sparsity_shadow = '0;
  logic [30:0]        tie_mags[6];

  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned hold_requests = 0;
  logic        bursty_sender = 1'b0;
  int unsigned burst_left = 0;

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned tiles_closed = 0;
  int unsigned weights_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;

  magnitude_prune_tile uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pruned.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // threshold is the magnitude of rank k, ties at the threshold are zeroed too
  task automatic predict_pruned_tile();
    mpt_pkg::out_item_t expect_item;
    logic [30:0] cut;
    logic [30:0] mag;
    int unsigned n, k, below, at_or_below, i, j;
    logic        zero_all, use_cut;
    n = pending_weights.size();
    zero_all = (sparsity_shadow >= 17'd65536);
    use_cut = 1'b0;
    cut = '0;
    if (!zero_all && sparsity_shadow != 17'd0) begin
      k = (n * sparsity_shadow) >> 16;
      if (k != 0 && k < n) begin
        use_cut = 1'b1;
        for (i = 0; i < n; i++) begin
          mag = pending_weights[i][30:0];
          below = 0;
          at_or_below = 0;
          for (j = 0; j < n; j++) begin
            if (pending_weights[j][30:0] < mag) below++;
            if (pending_weights[j][30:0] <= mag) at_or_below++;
          end
          if (below <= k && k < at_or_below) cut = mag;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      expect_item.pruned_bits = (zero_all || (use_cut && pending_weights[i][30:0] <= cut)) ?
                                32'd0 : pending_weights[i];
      expect_item.result_last = (i == n - 1);
      expected_pruned = {expected_pruned, expect_item};
    end
    pending_weights.delete();
    tiles_closed++;
  endtask

  always @(posedge clk_i) begin : monitor
    mpt_pkg::out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_weights = {pending_weights, in_item_i.weight_bits};
        if (in_item_i.tile_last || pending_weights.size() == mpt_pkg::TILE_DEPTH)
          predict_pruned_tile();
      end
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (expected_pruned.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected item bits %h last %b", $realtime,
                     out_item_o.pruned_bits, out_item_o.result_last);
          mismatch_count++;
        end else begin
          want = expected_pruned.pop_front();
          if (out_item_o.pruned_bits !== want.pruned_bits ||
              out_item_o.result_last !== want.result_last) begin
            if (mismatch_count < 10)
              $display("%0t: expected bits %h last %b, got bits %h last %b", $realtime,
                       want.pruned_bits, want.result_last,
                       out_item_o.pruned_bits, out_item_o.result_last);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    int unsigned hold_left;
    int unsigned hold_served;
    int unsigned tick;
    tick++;
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_ready_i <= 1'b1;
        RX_RANDOM:  out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_ready_i <= ((tick % 7) >= 3);
        default:    out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic send_weight(input logic [31:0] w, input logic last);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_item_i <= {w, last};
    do @(posedge clk_i); while (!in_ready_o);
    weights_sent++;
    @(negedge clk_i);
    if (bursty_sender) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pruned.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [mpt_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_sparsity_readback(input int unsigned value);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {mpt_pkg::REG_SPARSITY, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    if (readback !== value) begin
      if (mismatch_count < 10)
        $display("%0t: sparsity readback expected %h, got %h", $realtime, value, readback);
      mismatch_count++;
    end
  endtask

  task automatic set_sparsity(input int unsigned value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    apb_write({mpt_pkg::REG_SPARSITY, 2'b00}, value);
    sparsity_shadow = value[16:0];
    settings_used++;
    check_sparsity_readback(value);
  endtask

  function automatic logic [31:0] draw_weight(input weight_style_e style);
    logic [31:0] w;
    case (style)
      WS_TIES: begin
        w = {1'b0, tie_mags[$urandom_range(0, 5)]};
        w[31] = ($urandom_range(0, 1) == 1);
      end
      WS_SPECIAL: begin
        case ($urandom_range(0, 7))
          0:       w = 32'h0000_0000;
          1:       w = 32'h8000_0000;
          2:       w = 32'h7F80_0000;
          3:       w = 32'hFF80_0000;
          4:       w = 32'h7FC0_0000;
          5:       w = 32'hFFFF_FFFF;
          6:       w = 32'h7FFF_FFFF;
          default: w = 32'h0000_0001;
        endcase
      end
      default: w = $urandom();
    endcase
    return w;
  endfunction

  task automatic send_random_tile(input weight_style_e style);
    int unsigned len, pick, i;
    logic [31:0] raw;
    weight_style_e s;
    pick = $urandom_range(0, 99);
    if (pick < 72) len = $urandom_range(1, 12);
    else if (pick < 96) len = $urandom_range(13, 40);
    else len = mpt_pkg::TILE_DEPTH;
    foreach (tie_mags[t]) begin
      raw = $urandom();
      tie_mags[t] = raw[30:0];
    end
    for (i = 1; i <= len; i++) begin
      s = ($urandom_range(0, 4) == 0) ? WS_SPECIAL : style;
      send_weight(draw_weight(s),
                  (i == len) && (len < mpt_pkg::TILE_DEPTH || $urandom_range(0, 1) == 1));
    end
  endtask

  task automatic test_reset_passthrough();
    check_sparsity_readback(SPARS_NONE);
    send_weight(32'h0000_0000, 1'b0);
    send_weight(32'hFFFF_FFFF, 1'b0);
    send_weight(32'h8000_0000, 1'b0);
    send_weight(32'h7F80_0000, 1'b0);
    send_weight(32'h3F80_0000, 1'b1);
  endtask

  task automatic test_single_weight();
    set_sparsity(SPARS_HALF);
    send_weight(32'hC049_0FDB, 1'b1);
  endtask

  task automatic test_full_sparsity();
    set_sparsity(SPARS_FULL);
    send_weight(32'h8000_0000, 1'b0);
    send_weight(32'hBF80_0000, 1'b0);
    send_weight(32'h7FC0_0000, 1'b0);
    send_weight(32'hFFFF_FFFF, 1'b0);
    send_weight(32'h0000_0001, 1'b0);
    send_weight(32'h7F7F_FFFF, 1'b1);
  endtask

  task automatic test_rank_ties();
    set_sparsity(SPARS_HALF);
    send_weight(32'h3F80_0000, 1'b0);
    send_weight(32'hBF80_0000, 1'b0);
    send_weight(32'h3F80_0000, 1'b0);
    send_weight(32'h4000_0000, 1'b0);
    send_weight(32'h7FC0_0000, 1'b0);
    send_weight(32'h7F80_0000, 1'b0);
    send_weight(32'h0000_0000, 1'b0);
    send_weight(32'hC000_0000, 1'b1);
  endtask

  task automatic test_degenerate_k();
    set_sparsity(1);
    apb_write({~mpt_pkg::REG_SPARSITY, 2'b00}, SPARS_FULL);
    check_sparsity_readback(1);
    send_weight(32'h7FFF_FFFF, 1'b0);
    send_weight(32'h8000_0001, 1'b0);
    send_weight(32'h0000_0002, 1'b0);
    send_weight(32'h807F_FFFF, 1'b1);
  endtask

  task automatic test_full_buffer();
    int unsigned i;
    set_sparsity(SPARS_3Q);
    bursty_sender = 1'b1;
    for (i = 0; i < mpt_pkg::TILE_DEPTH; i++) send_weight(draw_weight(WS_RANDOM), 1'b0);
  endtask

  task automatic test_backpressure();
    int unsigned i;
    set_sparsity(SPARS_QUARTER);
    rx_mode <= RX_RANDOM;
    bursty_sender = 1'b0;
    hold_requests <= hold_requests + 1;
    for (i = 1; i <= 10; i++) send_weight(draw_weight(WS_RANDOM), i == 10);
    for (i = 1; i <= 12; i++) send_weight(draw_weight(WS_SPECIAL), i == 12);
    wait_drained();
    send_random_tile(WS_TIES);
  endtask

  task automatic test_random_tiles();
    int unsigned settings[8];
    int unsigned p, phase_start;
    settings[0] = SPARS_NONE;
    settings[1] = SPARS_FULL;
    settings[2] = SPARS_HALF;
    settings[3] = SPARS_FULL - 1;
    settings[4] = 1;
    settings[5] = SPARS_QUARTER;
    settings[6] = $urandom_range(1, SPARS_FULL - 1);
    settings[7] = SPARS_3Q;
    for (p = 0; p < 8; p++) begin
      set_sparsity(settings[p]);
      rx_mode <= rx_mode_e'(p % 4);
      bursty_sender = ((p % 3) != 2);
      phase_start = weights_sent;
      while (weights_sent - phase_start < 8)
        send_random_tile(weight_style_e'($urandom_range(0, 2)));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_passthrough();
    test_single_weight();
    test_full_sparsity();
    test_rank_ties();
    test_degenerate_k();
    test_full_buffer();
    test_backpressure();
    test_random_tiles();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("%0d weights in %0d tiles, %0d pruned results checked, %0d sparsity settings",
             weights_sent, tiles_closed, results_checked, settings_used);
    $display("ties, nan and infinity ranking, full buffer and a long output hold-off included");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
